FILE: rtl/core/sdds_pkg.sv
package sdds_pkg;

  // Fixed sizes of the oscillator
  localparam int TABLE_ADDR_BITS = 10;
  localparam int PHASE_BITS      = 32;
  localparam int SAMPLE_BITS     = 16;

  localparam int QUARTER_BITS = TABLE_ADDR_BITS - 2;
  localparam int QUARTER_SIZE = 1 << QUARTER_BITS;
  localparam int MAG_BITS     = SAMPLE_BITS - 1;
  localparam int SAMPLE_MAX   = (1 << MAG_BITS) - 1;

  // Gain arithmetic: target Q1.16, running gain Q1.31
  localparam int TARGET_W   = 17;
  localparam int GAIN_W     = 32;
  localparam int GAIN_SHIFT = 15;
  localparam int STEP_W     = GAIN_W + 1;
  localparam int RAMP_W     = 16;
  localparam logic [TARGET_W-1:0] GAIN_MAX = TARGET_W'(65536);

  // Shift-add product of table magnitude and gain
  localparam int PROD_W      = GAIN_W + MAG_BITS;
  localparam int ROUND_SHIFT = GAIN_W - 1;
  localparam int RES_W       = PROD_W + 1 - ROUND_SHIFT;
  localparam int MUL_CNT_W   = $clog2(MAG_BITS + 1);
  localparam int DIV_CNT_W   = $clog2(STEP_W + 1);

  // Stream widths
  localparam int IN_FIELDS_W  = 32 + TARGET_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 32;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_INC  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_RAMP_STEPS = CFG_INDEX_W'(1);

  localparam logic [31:0]       PHASE_INC_RESET  = 32'd39370534;
  localparam logic [RAMP_W-1:0] RAMP_STEPS_RESET = RAMP_W'(480);

  localparam int PHASE_SHL = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
  localparam int PHASE_SHR = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;

  typedef logic [PHASE_BITS-1:0] phase_t;
  typedef logic [QUARTER_SIZE-1:0][MAG_BITS-1:0] sine_tab_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TGT,
    ST_DIV,
    ST_GAIN,
    ST_MUL,
    ST_OUT
  } state_t;

  // Align a 0.32 cycle fraction to the accumulator width
  function automatic phase_t align_phase(input logic [31:0] v);
    logic [PHASE_BITS+31:0] wide;
    wide = (PHASE_BITS + 32)'(v);
    wide = (wide << PHASE_SHL) >> PHASE_SHR;
    return wide[PHASE_BITS-1:0];
  endfunction

  // Unsigned long division for table construction, one quotient bit a pass
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave table, fixed-point Taylor series evaluated at elaboration
  function automatic sine_tab_t build_sine_table();
    sine_tab_t         tab;
    longint unsigned   num;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sum;
    longint            ent;
    for (int i = 0; i < QUARTER_SIZE; i++) begin
      num  = 64'd3373259426 * (2 * longint'(i) + 1);
      x    = (num + (64'd1 << (TABLE_ADDR_BITS - 1))) >> TABLE_ADDR_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 9; n++) begin
        term = udiv64((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
        if ((n & 1) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      ent = (sum * SAMPLE_MAX + (64'sd1 <<< 29)) >>> 30;
      tab[i] = ent[MAG_BITS-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage

FILE: rtl/core/sine_dds_with_fm_and_gain_ramp_top.sv
// Channel | Direction | Handshake          | Payload
// s       | in        | s_tvalid/s_tready  | s_tdata: fm_offset, gain_target
// m       | out       | m_tvalid/m_tready  | m_tdata: sample
// cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each sample passes from transfer in to result ready through the target
// check, the gain update, the bit-serial gain multiply (one magnitude bit a
// cycle) and the load of the output register. A change of gain target with
// a nonzero ramp length adds a pass through the restoring divider (one
// quotient bit a cycle). Reset is synchronous and clears control state and
// the oscillator state. A stalled output holds its sample; the next item is
// taken meanwhile and waits in its last step until the output frees.
module sine_dds_with_fm_and_gain_ramp_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [sdds_pkg::IN_TDATA_W-1:0]      s_tdata,   // fm_offset, gain_target
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [sdds_pkg::OUT_TDATA_W-1:0]     m_tdata,   // sample
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sdds_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sdds_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int PB  = sdds_pkg::PHASE_BITS;
  localparam int MB  = sdds_pkg::MAG_BITS;
  localparam int GW  = sdds_pkg::GAIN_W;
  localparam int TW  = sdds_pkg::TARGET_W;
  localparam int SW  = sdds_pkg::STEP_W;
  localparam int RW  = sdds_pkg::RAMP_W;
  localparam int SB  = sdds_pkg::SAMPLE_BITS;
  localparam int TAB = sdds_pkg::TABLE_ADDR_BITS;
  localparam int QB  = sdds_pkg::QUARTER_BITS;

  sdds_pkg::state_t state, state_next;

  // Configuration and oscillator state
  logic [31:0]              phase_inc;
  logic [RW-1:0]            ramp_steps;
  sdds_pkg::phase_t         phase_acc;
  logic [GW-1:0]            current_gain;
  logic [TW-1:0]            stored_target;
  logic [SW-1:0]            gain_step;
  logic [RW-1:0]            ramp_countdown;

  // Per-item working registers
  logic [TW-1:0]            tgt;
  logic [MB-1:0]            mag;
  logic                     neg;
  logic [SW-1:0]            div_q;
  logic [RW-1:0]            div_rem;
  logic                     div_neg;
  logic [sdds_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [GW-1:0]            prod_hi;
  logic [MB-1:0]            prod_lo;
  logic [sdds_pkg::MUL_CNT_W-1:0] mul_cnt;
  logic [SB-1:0]            sample;

  logic                     s_xfer;
  logic                     cfg_xfer;
  logic                     out_free;

  // Input fields
  logic [31:0]              fm_offset;
  logic [TW-1:0]            gain_target;
  logic [TW-1:0]            tgt_clamp;

  // Lookup path
  sdds_pkg::phase_t         look_phase;
  logic [TAB-1:0]           addr;
  logic [QB-1:0]            idx;

  // Target check
  logic                     tgt_change;
  logic                     ramp_off;
  logic [GW+1:0]            diff;
  logic [GW+1:0]            diff_abs;

  // Divider step
  logic [RW:0]              trial;
  logic [RW:0]              trial_sub;
  logic                     trial_ge;
  logic                     div_last;

  // Gain advance
  logic [RW-1:0]            cd_dec;

  // Multiply and round
  logic [GW:0]              mul_sum;
  logic                     mul_last;
  logic [sdds_pkg::PROD_W:0] round_sum;
  logic [sdds_pkg::RES_W-1:0] res;
  logic [MB-1:0]            res_sat;
  logic [SB-1:0]            res_signed;

  assign s_tready  = (state == sdds_pkg::ST_IDLE);
  assign cfg_ready = (state == sdds_pkg::ST_IDLE);
  assign s_xfer    = s_tvalid && s_tready;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign out_free  = !m_tvalid || m_tready;
  assign m_tdata   = sdds_pkg::OUT_TDATA_W'(sample);

  assign fm_offset   = s_tdata[31:0];
  assign gain_target = s_tdata[32 +: TW];
  assign tgt_clamp   = (gain_target > sdds_pkg::GAIN_MAX) ? sdds_pkg::GAIN_MAX : gain_target;

  // Quarter-wave lookup with mirror and sign by quadrant
  assign look_phase = phase_acc + sdds_pkg::align_phase(fm_offset);
  assign addr       = look_phase[PB-1 -: TAB];
  assign idx        = addr[TAB-2] ? ~addr[QB-1:0] : addr[QB-1:0];

  // Distance from running gain to new target
  assign tgt_change = (tgt != stored_target);
  assign ramp_off   = (ramp_steps == '0);
  assign diff       = {2'b00, tgt, {sdds_pkg::GAIN_SHIFT{1'b0}}} - {2'b00, current_gain};
  assign diff_abs   = diff[GW+1] ? (~diff + (GW+2)'(1)) : diff;

  // Restoring division, one quotient bit a cycle
  assign trial     = {div_rem, div_q[SW-1]};
  assign trial_sub = trial - {1'b0, ramp_steps};
  assign trial_ge  = (trial >= {1'b0, ramp_steps});
  assign div_last  = (div_cnt == sdds_pkg::DIV_CNT_W'(SW - 1));

  assign cd_dec = ramp_countdown - RW'(1);

  // Shift-add multiply, one magnitude bit a cycle
  assign mul_sum  = {1'b0, prod_hi} + (prod_lo[0] ? {1'b0, current_gain} : '0);
  assign mul_last = (mul_cnt == sdds_pkg::MUL_CNT_W'(MB - 1));

  // Round half away from zero on the magnitude, saturate, apply sign
  assign round_sum  = {1'b0, prod_hi, prod_lo} +
                      ((sdds_pkg::PROD_W + 1)'(1) << (sdds_pkg::ROUND_SHIFT - 1));
  assign res        = round_sum[sdds_pkg::PROD_W:sdds_pkg::ROUND_SHIFT];
  assign res_sat    = (res > sdds_pkg::RES_W'(sdds_pkg::SAMPLE_MAX)) ?
                      MB'(sdds_pkg::SAMPLE_MAX) : res[MB-1:0];
  assign res_signed = neg ? (~{1'b0, res_sat} + SB'(1)) : {1'b0, res_sat};

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdds_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      sdds_pkg::ST_IDLE: begin
        if (s_xfer) state_next = sdds_pkg::ST_TGT;
      end
      sdds_pkg::ST_TGT: begin
        if (tgt_change && !ramp_off) state_next = sdds_pkg::ST_DIV;
        else                         state_next = sdds_pkg::ST_GAIN;
      end
      sdds_pkg::ST_DIV: begin
        if (div_last) state_next = sdds_pkg::ST_GAIN;
      end
      sdds_pkg::ST_GAIN: state_next = sdds_pkg::ST_MUL;
      sdds_pkg::ST_MUL: begin
        if (mul_last) state_next = sdds_pkg::ST_OUT;
      end
      sdds_pkg::ST_OUT: begin
        if (out_free) state_next = sdds_pkg::ST_IDLE;
      end
      default: state_next = sdds_pkg::ST_IDLE;
    endcase
  end

  // Oscillator and gain state, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_inc      <= sdds_pkg::PHASE_INC_RESET;
      ramp_steps     <= sdds_pkg::RAMP_STEPS_RESET;
      phase_acc      <= '0;
      current_gain   <= '0;
      stored_target  <= '0;
      gain_step      <= '0;
      ramp_countdown <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      // Raise the result when loaded, drop it once it is transferred
      if (state == sdds_pkg::ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_xfer) begin
        case (cfg_index)
          sdds_pkg::REG_PHASE_INC: phase_inc <= cfg_data;
          sdds_pkg::REG_RAMP_STEPS: begin
            ramp_steps     <= cfg_data[RW-1:0];
            current_gain   <= {stored_target, {sdds_pkg::GAIN_SHIFT{1'b0}}};
            ramp_countdown <= '0;
            gain_step      <= '0;
          end
          default: ;
        endcase
      end

      case (state)
        sdds_pkg::ST_IDLE: begin
          if (s_xfer) phase_acc <= phase_acc + sdds_pkg::align_phase(phase_inc);
        end
        sdds_pkg::ST_TGT: begin
          if (tgt_change) begin
            stored_target <= tgt;
            if (ramp_off) begin
              current_gain   <= {tgt, {sdds_pkg::GAIN_SHIFT{1'b0}}};
              ramp_countdown <= '0;
            end else begin
              ramp_countdown <= ramp_steps;
            end
          end
        end
        sdds_pkg::ST_DIV: begin
          if (div_last) begin
            gain_step <= div_neg ? (~{div_q[SW-2:0], trial_ge} + SW'(1))
                                 : {div_q[SW-2:0], trial_ge};
          end
        end
        sdds_pkg::ST_GAIN: begin
          // Advance the ramp by one sample
          if (ramp_countdown != '0) begin
            ramp_countdown <= cd_dec;
            if (cd_dec != '0) begin
              current_gain <= current_gain + gain_step[GW-1:0];
            end else begin
              current_gain <= {stored_target, {sdds_pkg::GAIN_SHIFT{1'b0}}};
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      sdds_pkg::ST_IDLE: begin
        if (s_xfer) begin
          tgt <= tgt_clamp;
          mag <= sdds_pkg::SINE_TABLE[idx];
          neg <= addr[TAB-1];
        end
      end
      sdds_pkg::ST_TGT: begin
        div_q   <= diff_abs[SW-1:0];
        div_neg <= diff[GW+1];
        div_rem <= '0;
        div_cnt <= '0;
      end
      sdds_pkg::ST_DIV: begin
        div_rem <= trial_ge ? trial_sub[RW-1:0] : trial[RW-1:0];
        div_q   <= {div_q[SW-2:0], trial_ge};
        div_cnt <= div_cnt + sdds_pkg::DIV_CNT_W'(1);
      end
      sdds_pkg::ST_GAIN: begin
        prod_hi <= '0;
        prod_lo <= mag;
        mul_cnt <= '0;
      end
      sdds_pkg::ST_MUL: begin
        prod_hi <= mul_sum[GW:1];
        prod_lo <= {mul_sum[0], prod_lo[MB-1:1]};
        mul_cnt <= mul_cnt + sdds_pkg::MUL_CNT_W'(1);
      end
      sdds_pkg::ST_OUT: begin
        if (out_free) sample <= res_signed;
      end
      default: ;
    endcase
  end

  // Input is taken only between items
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != sdds_pkg::ST_IDLE) |-> !s_tready)
    else $error("input ready while an item is in flight");

  // Ramp countdown never exceeds the configured length
  a_countdown_bound: assert property (@(posedge clk) disable iff (rst)
    ramp_countdown <= ramp_steps)
    else $error("ramp countdown above ramp length");

  // Running gain stays within unity
  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    current_gain <= {sdds_pkg::GAIN_MAX, {sdds_pkg::GAIN_SHIFT{1'b0}}})
    else $error("gain above one");

  // A result loaded into a free output register is presented as valid
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == sdds_pkg::ST_OUT && out_free) |=> m_tvalid)
    else $error("result not presented after output step");

endmodule
